// ===== rtl/wfpa_pkg.sv =====
package wfpa_pkg;

    localparam int MAX_SLOTS = 16;
    localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int COUNT_W   = $clog2(MAX_SLOTS + 1);
    localparam int SIZE_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 4;

    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_REQ = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_ADDED   = 2'd0,
        STATUS_REFUSED = 2'd1,
        STATUS_GRANTED = 2'd2,
        STATUS_NOFIT   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_FINISH
    } fsm_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             take_en;
        logic [IDX_W-1:0] take_addr;
        logic [IDX_W-1:0] rd_addr;
    } store_cmd_t;

    typedef struct packed {
        logic             clear;
        logic             en;
        logic [IDX_W-1:0] idx;
    } scan_ctl_t;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  best_idx;
        logic [SIZE_W-1:0] best_left;
    } scan_res_t;

    function automatic logic [SLOT_W-1:0] to_slot_index(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

// ===== rtl/wfpa_if.sv =====
interface wfpa_in_if;
    import wfpa_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [SIZE_W-1:0] amount;

    modport source (output valid, output kind, output amount, input ready);
    modport sink (input valid, input kind, input amount, output ready);
endinterface

interface wfpa_out_if;
    import wfpa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic [SIZE_W-1:0]   leftover;

    modport source (output valid, output status, output slot_index, output leftover,
                    input ready);
    modport sink (input valid, input status, input slot_index, input leftover,
                  output ready);
endinterface

// ===== rtl/wfpa_slot_store.sv =====
module wfpa_slot_store (
    input  logic                        clk,
    input  logic                        rst_n,
    input  wfpa_pkg::store_cmd_t        cmd,
    input  logic [wfpa_pkg::SIZE_W-1:0] wr_size,
    output logic [wfpa_pkg::SIZE_W-1:0] rd_size,
    output logic                        rd_taken
);
    import wfpa_pkg::*;

    logic [SIZE_W-1:0]    size_mem [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] taken_reg;
    logic [SIZE_W-1:0]    rd_size_reg;
    logic                 rd_taken_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            size_mem[cmd.wr_addr] <= wr_size;
        end
        rd_size_reg  <= size_mem[cmd.rd_addr];
        rd_taken_reg <= taken_reg[cmd.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= '0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                taken_reg[cmd.wr_addr] <= 1'b0;
            end
            if (cmd.take_en)
            begin
                taken_reg[cmd.take_addr] <= 1'b1;
            end
        end
    end

    assign rd_size  = rd_size_reg;
    assign rd_taken = rd_taken_reg;

endmodule

// ===== rtl/wfpa_scan_unit.sv =====
module wfpa_scan_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  wfpa_pkg::scan_ctl_t         ctl,
    input  logic [wfpa_pkg::SIZE_W-1:0] amount,
    input  logic [wfpa_pkg::SIZE_W-1:0] size,
    input  logic                        taken,
    output wfpa_pkg::scan_res_t         res
);
    import wfpa_pkg::*;

    logic              found_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [SIZE_W-1:0] best_left_reg;
    logic [SIZE_W:0]   diff;
    logic              fits;
    logic              better;

    // borrow out of the subtract means the slot is too small
    assign diff   = {1'b0, size} - {1'b0, amount};
    assign fits   = !taken && !diff[SIZE_W];
    assign better = fits && (!found_reg || (diff[SIZE_W-1:0] > best_left_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.en && better)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            best_idx_reg  <= '0;
            best_left_reg <= '0;
        end
        else if (ctl.en && better)
        begin
            best_idx_reg  <= ctl.idx;
            best_left_reg <= diff[SIZE_W-1:0];
        end
    end

    assign res.found     = found_reg;
    assign res.best_idx  = best_idx_reg;
    assign res.best_left = best_left_reg;

endmodule

// ===== rtl/worst_fit_partition_allocator.sv =====
// Worst-fit fixed-partition allocator.
// item channel (sink): kind 0 adds a partition of size amount, kind 1 asks for
// a block of size amount. result channel (source): one beat per item beat,
// carrying status, slot_index and leftover.
// cfg_we/cfg_wdata write total_memory; write only while the block is idle.
// A partition beat is resolved in the accept cycle; its result is registered,
// moves through FINISH into the output register, and the block then returns
// to idle for the next item. A request beat walks the held partitions one per
// cycle through the shared subtract/compare unit, with a registered read of
// the size table; after the last compare the grant or no-fit result goes
// through FINISH into the output register before the next item is taken.
// item.ready is low while a request is being scanned or a result waits for
// the output register; one finished result may sit in the output register
// while the next item is accepted.
// If the receiver stalls, the result beat holds and the block stops after
// the next item is resolved.
// Reset empties the table, frees all slots, reopens loading and sets
// total_memory to 65535. No clearing pass is needed.
module worst_fit_partition_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [wfpa_pkg::SIZE_W-1:0] cfg_wdata,
    wfpa_in_if.sink                     item,
    wfpa_out_if.source                  result
);
    import wfpa_pkg::*;

    fsm_t                state_reg, state_next;
    logic [SIZE_W-1:0]   total_memory_reg;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [SIZE_W-1:0]   claimed_reg, claimed_next;
    logic                closed_reg, closed_next;
    logic [SIZE_W-1:0]   amount_reg, amount_next;
    logic [COUNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    status_t             res_status_reg, res_status_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic [SIZE_W-1:0]   res_left_reg, res_left_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [SIZE_W-1:0]   out_left_reg;
    logic                out_load;

    store_cmd_t          store_cmd;
    scan_ctl_t           scan_ctl;
    scan_res_t           scan_res;
    logic [SIZE_W-1:0]   rd_size;
    logic                rd_taken;
    logic [SIZE_W:0]     sum;
    logic                accept;
    logic                issue;

    wfpa_slot_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (store_cmd),
        .wr_size  (item.amount),
        .rd_size  (rd_size),
        .rd_taken (rd_taken)
    );

    wfpa_scan_unit u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (scan_ctl),
        .amount (amount_reg),
        .size   (rd_size),
        .taken  (rd_taken),
        .res    (scan_res)
    );

    assign item.ready = (state_reg == FSM_IDLE);
    assign accept     = item.valid && item.ready;
    assign sum        = {1'b0, claimed_reg} + {1'b0, item.amount};
    assign issue      = (scan_idx_reg < count_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        claimed_next    = claimed_reg;
        closed_next     = closed_reg;
        amount_next     = amount_reg;
        scan_idx_next   = scan_idx_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_left_next   = res_left_reg;
        out_load        = 1'b0;
        store_cmd       = '0;
        scan_ctl        = '0;

        store_cmd.wr_addr   = count_reg[IDX_W-1:0];
        store_cmd.take_addr = scan_res.best_idx;
        store_cmd.rd_addr   = scan_idx_reg[IDX_W-1:0];
        scan_ctl.en         = rd_pend_reg;
        scan_ctl.idx        = rd_idx_reg;

        case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    amount_next   = item.amount;
                    res_slot_next = '0;
                    res_left_next = '0;
                    if (item.kind == KIND_REQ)
                    begin
                        scan_idx_next  = '0;
                        scan_ctl.clear = 1'b1;
                        state_next     = FSM_SCAN;
                    end
                    else
                    begin
                        state_next = FSM_FINISH;
                        if (closed_reg || (count_reg == COUNT_W'(MAX_SLOTS)))
                        begin
                            res_status_next = STATUS_REFUSED;
                        end
                        else if (sum > {1'b0, total_memory_reg})
                        begin
                            closed_next     = 1'b1;
                            res_status_next = STATUS_REFUSED;
                        end
                        else
                        begin
                            store_cmd.wr_en = 1'b1;
                            claimed_next    = sum[SIZE_W-1:0];
                            count_next      = count_reg + 1'b1;
                            res_status_next = STATUS_ADDED;
                            res_slot_next   = to_slot_index(count_reg[IDX_W-1:0]);
                        end
                    end
                end
            end
            FSM_SCAN:
            begin
                if (issue)
                begin
                    rd_pend_next  = 1'b1;
                    rd_idx_next   = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else if (!rd_pend_reg)
                begin
                    state_next = FSM_FINISH;
                    if (scan_res.found)
                    begin
                        store_cmd.take_en = 1'b1;
                        res_status_next   = STATUS_GRANTED;
                        res_slot_next     = to_slot_index(scan_res.best_idx);
                        res_left_next     = scan_res.best_left;
                    end
                    else
                    begin
                        res_status_next = STATUS_NOFIT;
                    end
                end
            end
            FSM_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= FSM_IDLE;
            total_memory_reg <= '1;
            count_reg        <= '0;
            claimed_reg      <= '0;
            closed_reg       <= 1'b0;
            scan_idx_reg     <= '0;
            rd_pend_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            claimed_reg   <= claimed_next;
            closed_reg    <= closed_next;
            scan_idx_reg  <= scan_idx_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                total_memory_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        amount_reg     <= amount_next;
        rd_idx_reg     <= rd_idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_left_reg   <= res_left_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_left_reg   <= res_left_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.status     = out_status_reg;
    assign result.slot_index = out_slot_reg;
    assign result.leftover   = out_left_reg;

endmodule
